// ===== src/kbog_pkg.sv =====
// Shared types, constants and helper functions for the kernel block offset generator.
// Used by the channel interfaces, every pipeline stage and the top level.
package kbog_pkg;

   localparam int DEFAULT_BLOCK_SIZE      = 4;
   localparam int DEFAULT_BLOCKS_PER_SIDE = 8;

   localparam int INDEX_WIDTH  = 5;
   localparam int OFFSET_WIDTH = 10;
   localparam int MODE_WIDTH   = 2;
   localparam int SIDE_WIDTH   = 13;

   // Reciprocal division of a five bit index by the block size.
   localparam int DIV_SHIFT      = 12;
   localparam int RECIP_WIDTH    = 13;
   localparam int DIV_PROD_WIDTH = INDEX_WIDTH + RECIP_WIDTH;

   typedef logic [INDEX_WIDTH-1:0]  index_type;
   typedef logic [OFFSET_WIDTH-1:0] offset_type;

   typedef enum logic [MODE_WIDTH-1:0] {
      LAYOUT_DENSE_COL = 2'd0,
      LAYOUT_BLOCK_ROW = 2'd1,
      LAYOUT_BLOCK_Z   = 2'd2
   } layout_type;

   typedef struct packed {
      index_type row_index;
      index_type col_index;
      logic      transpose_access;
   } req_word_type;

   typedef struct packed {
      index_type row_block;
      index_type col_block;
      index_type row_index;
      index_type col_index;
      logic      transpose_access;
      logic      range_error;
   } split_word_type;

   typedef struct packed {
      offset_type inner_offset;
      offset_type dense_offset;
      offset_type linear_block;
      offset_type morton_block;
      logic       range_error;
   } map_word_type;

   typedef struct packed {
      offset_type word_offset;
      logic       range_error;
   } rsp_word_type;

   // Column bit k goes to position 2k, row bit k to position 2k+1.
   function automatic offset_type morton_pair(input index_type row_blk,
                                              input index_type col_blk);
      offset_type acc;
      acc = '0;
      for (int k = 0; k < INDEX_WIDTH; k++) begin
         acc[2*k]   = col_blk[k];
         acc[2*k+1] = row_blk[k];
      end
      return acc;
   endfunction

endpackage

// ===== src/kbog_req_if.sv =====
// Request channel carrying one row, column and transpose word per handshake.
// Depends on kbog_pkg for the index type.
interface kbog_req_if;
   import kbog_pkg::*;

   logic      valid;
   logic      ready;
   index_type row_index;
   index_type col_index;
   logic      transpose_access;

   modport source (output valid, output row_index, output col_index,
                   output transpose_access, input ready);
   modport sink (input valid, input row_index, input col_index,
                 input transpose_access, output ready);
endinterface

// ===== src/kbog_rsp_if.sv =====
// Response channel carrying one word offset and error flag per handshake.
// Depends on kbog_pkg for the offset type.
interface kbog_rsp_if;
   import kbog_pkg::*;

   logic       valid;
   logic       ready;
   offset_type word_offset;
   logic       range_error;

   modport source (output valid, output word_offset, output range_error, input ready);
   modport sink (input valid, input word_offset, input range_error, output ready);
endinterface

// ===== src/kernel_block_offset_generator.sv =====
// Kernel block offset generator: top level with the layout register and three stages.
// Depends on kbog_pkg, kbog_req_if, kbog_rsp_if, kbog_split, kbog_map and kbog_select.
//
// Each request word on req_word carries a row, a column and a transpose flag for
// one element of a kernel tile; the block answers with one response word on
// rsp_word holding the word offset of that element in the tile store and a
// range error flag. csr_write_enable and csr_write_data set the layout mode
// (dense column major, blocked row major or blocked Z-curve); write it only
// while no request is in flight.
// A request word passes through three register stages in order: bounds check and
// block split, coordinate mapping, layout select. rsp_word.valid and the response
// word come from the last of them.
// Throughput is one word per cycle while the receiver holds rsp_word.ready high.
// A synchronous reset empties the pipeline and sets the dense column layout.
// When the receiver holds off ready, the response register keeps its word and
// the stages behind it keep filling until each holds a word, then req ready drops.
module kernel_block_offset_generator #(
   parameter int BLOCK_SIZE      = kbog_pkg::DEFAULT_BLOCK_SIZE,
   parameter int BLOCKS_PER_SIDE = kbog_pkg::DEFAULT_BLOCKS_PER_SIDE
) (
   input  logic                             clock,
   input  logic                             reset,
   kbog_req_if.sink                         req_word,
   kbog_rsp_if.source                       rsp_word,
   input  logic                             csr_write_enable,
   input  logic [kbog_pkg::MODE_WIDTH-1:0]  csr_write_data
);
   import kbog_pkg::*;

   logic [MODE_WIDTH-1:0] layout_mode_ff, layout_mode_in;
   req_word_type          req_data;
   logic                  split_valid, split_ready;
   split_word_type        split_data;
   logic                  map_valid, map_ready;
   map_word_type          map_data;
   rsp_word_type          rsp_data;

   assign layout_mode_in = csr_write_enable ? csr_write_data : layout_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         layout_mode_ff <= LAYOUT_DENSE_COL;
      end else begin
         layout_mode_ff <= layout_mode_in;
      end
   end

   assign req_data.row_index        = req_word.row_index;
   assign req_data.col_index        = req_word.col_index;
   assign req_data.transpose_access = req_word.transpose_access;

   kbog_split #(
      .BLOCK_SIZE      (BLOCK_SIZE),
      .BLOCKS_PER_SIDE (BLOCKS_PER_SIDE)
   ) u_split (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_word.valid),
      .in_data   (req_data),
      .in_ready  (req_word.ready),
      .out_valid (split_valid),
      .out_data  (split_data),
      .out_ready (split_ready)
   );

   kbog_map #(
      .BLOCK_SIZE      (BLOCK_SIZE),
      .BLOCKS_PER_SIDE (BLOCKS_PER_SIDE)
   ) u_map (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (split_valid),
      .in_data   (split_data),
      .in_ready  (split_ready),
      .out_valid (map_valid),
      .out_data  (map_data),
      .out_ready (map_ready)
   );

   kbog_select #(
      .BLOCK_SIZE (BLOCK_SIZE)
   ) u_select (
      .clock       (clock),
      .reset       (reset),
      .layout_mode (layout_mode_ff),
      .in_valid    (map_valid),
      .in_data     (map_data),
      .in_ready    (map_ready),
      .out_valid   (rsp_word.valid),
      .out_data    (rsp_data),
      .out_ready   (rsp_word.ready)
   );

   assign rsp_word.word_offset = rsp_data.word_offset;
   assign rsp_word.range_error = rsp_data.range_error;

   a_error_zero_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_word.valid && rsp_word.range_error |-> rsp_word.word_offset == '0)
      else $error("range error word with nonzero offset");

   a_unused_mode_error: assert property (@(posedge clock) disable iff (reset)
      rsp_word.valid && (layout_mode_ff == 2'd3) |-> rsp_word.range_error)
      else $error("unused layout code did not flag an error");

   a_map_stall_holds: assert property (@(posedge clock) disable iff (reset)
      map_valid && !map_ready |=> map_valid && $stable(map_data))
      else $error("stalled mapping stage lost or changed its word");

   a_split_stall_holds: assert property (@(posedge clock) disable iff (reset)
      split_valid && !split_ready |=> split_valid && $stable(split_data))
      else $error("stalled split stage lost or changed its word");
endmodule

// ===== src/kbog_split.sv =====
// First pipeline stage: bounds check and split of the indices into block coordinates.
// Depends on kbog_pkg for the word types and division constants.
module kbog_split #(
   parameter int BLOCK_SIZE      = kbog_pkg::DEFAULT_BLOCK_SIZE,
   parameter int BLOCKS_PER_SIDE = kbog_pkg::DEFAULT_BLOCKS_PER_SIDE
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  kbog_pkg::req_word_type   in_data,
   output logic                     in_ready,
   output logic                     out_valid,
   output kbog_pkg::split_word_type out_data,
   input  logic                     out_ready
);
   import kbog_pkg::*;

   localparam logic [SIDE_WIDTH-1:0]  TILE_SIDE = SIDE_WIDTH'(BLOCK_SIZE * BLOCKS_PER_SIDE);
   localparam logic [RECIP_WIDTH-1:0] RECIP =
      RECIP_WIDTH'(((1 << DIV_SHIFT) + BLOCK_SIZE - 1) / BLOCK_SIZE);

   logic                        valid_ff, valid_in;
   split_word_type              data_ff, data_in;
   logic [DIV_PROD_WIDTH-1:0]   row_prod, col_prod;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      row_prod = DIV_PROD_WIDTH'(in_data.row_index) * DIV_PROD_WIDTH'(RECIP);
      col_prod = DIV_PROD_WIDTH'(in_data.col_index) * DIV_PROD_WIDTH'(RECIP);
      valid_in = in_ready ? in_valid : valid_ff;
      data_in  = data_ff;
      if (in_ready && in_valid) begin
         data_in.row_block        = row_prod[DIV_SHIFT +: INDEX_WIDTH];
         data_in.col_block        = col_prod[DIV_SHIFT +: INDEX_WIDTH];
         data_in.row_index        = in_data.row_index;
         data_in.col_index        = in_data.col_index;
         data_in.transpose_access = in_data.transpose_access;
         data_in.range_error      = (SIDE_WIDTH'(in_data.row_index) >= TILE_SIDE) ||
                                    (SIDE_WIDTH'(in_data.col_index) >= TILE_SIDE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule

// ===== src/kbog_map.sv =====
// Second pipeline stage: in-block offset, dense offset and both block index forms.
// Depends on kbog_pkg for the word types and the interleave function.
module kbog_map #(
   parameter int BLOCK_SIZE      = kbog_pkg::DEFAULT_BLOCK_SIZE,
   parameter int BLOCKS_PER_SIDE = kbog_pkg::DEFAULT_BLOCKS_PER_SIDE
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  kbog_pkg::split_word_type in_data,
   output logic                     in_ready,
   output logic                     out_valid,
   output kbog_pkg::map_word_type   out_data,
   input  logic                     out_ready
);
   import kbog_pkg::*;

   localparam int         BS_PROD_WIDTH = INDEX_WIDTH + 7;
   localparam offset_type BS_OFF  = OFFSET_WIDTH'(BLOCK_SIZE);
   localparam offset_type BPS_OFF = OFFSET_WIDTH'(BLOCKS_PER_SIDE);
   localparam offset_type TS_OFF  = OFFSET_WIDTH'((BLOCK_SIZE * BLOCKS_PER_SIDE) % 1024);

   logic                     valid_ff, valid_in;
   map_word_type             data_ff, data_in;
   logic [BS_PROD_WIDTH-1:0] row_base, col_base;
   index_type                row_inner, col_inner;
   offset_type               row_ext, col_ext;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      row_base  = BS_PROD_WIDTH'(in_data.row_block) * BS_PROD_WIDTH'(BLOCK_SIZE);
      col_base  = BS_PROD_WIDTH'(in_data.col_block) * BS_PROD_WIDTH'(BLOCK_SIZE);
      row_inner = in_data.row_index - row_base[INDEX_WIDTH-1:0];
      col_inner = in_data.col_index - col_base[INDEX_WIDTH-1:0];
      row_ext   = OFFSET_WIDTH'(in_data.row_index);
      col_ext   = OFFSET_WIDTH'(in_data.col_index);
      valid_in  = in_ready ? in_valid : valid_ff;
      data_in   = data_ff;
      if (in_ready && in_valid) begin
         if (in_data.transpose_access) begin
            data_in.inner_offset = OFFSET_WIDTH'(col_inner) * BS_OFF + OFFSET_WIDTH'(row_inner);
            data_in.dense_offset = col_ext + row_ext * TS_OFF;
         end else begin
            data_in.inner_offset = OFFSET_WIDTH'(row_inner) * BS_OFF + OFFSET_WIDTH'(col_inner);
            data_in.dense_offset = row_ext + col_ext * TS_OFF;
         end
         data_in.linear_block = OFFSET_WIDTH'(in_data.row_block) * BPS_OFF +
                                OFFSET_WIDTH'(in_data.col_block);
         data_in.morton_block = morton_pair(in_data.row_block, in_data.col_block);
         data_in.range_error  = in_data.range_error;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule

// ===== src/kbog_select.sv =====
// Third pipeline stage and output register: layout select and block scaling.
// Depends on kbog_pkg for the word types and layout codes.
module kbog_select #(
   parameter int BLOCK_SIZE = kbog_pkg::DEFAULT_BLOCK_SIZE
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [kbog_pkg::MODE_WIDTH-1:0] layout_mode,
   input  logic                         in_valid,
   input  kbog_pkg::map_word_type       in_data,
   output logic                         in_ready,
   output logic                         out_valid,
   output kbog_pkg::rsp_word_type       out_data,
   input  logic                         out_ready
);
   import kbog_pkg::*;

   localparam offset_type BLOCK_AREA = OFFSET_WIDTH'((BLOCK_SIZE * BLOCK_SIZE) % 1024);

   logic         valid_ff, valid_in;
   rsp_word_type data_ff, data_in;
   offset_type   block_index;
   offset_type   offset;
   logic         error;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      block_index = in_data.linear_block;
      offset      = '0;
      error       = in_data.range_error;
      case (layout_mode)
         LAYOUT_DENSE_COL: begin
            offset = in_data.dense_offset;
         end
         LAYOUT_BLOCK_ROW: begin
            block_index = in_data.linear_block;
            offset      = in_data.inner_offset + block_index * BLOCK_AREA;
         end
         LAYOUT_BLOCK_Z: begin
            block_index = in_data.morton_block;
            offset      = in_data.inner_offset + block_index * BLOCK_AREA;
         end
         default: begin
            error = 1'b1;
         end
      endcase
      valid_in = in_ready ? in_valid : valid_ff;
      data_in  = data_ff;
      if (in_ready && in_valid) begin
         data_in.word_offset = error ? '0 : offset;
         data_in.range_error = error;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule
